// ===== sv/uer_pkg.sv =====
// shared constants, types and helper functions of the ultrasonic echo ranger
package uer_pkg;

  localparam int COUNTER_BITS = 20;

  localparam int TRIG_W  = 10;
  localparam int LIMIT_W = 20;
  localparam int SCALE_W = 16;
  localparam int DIST_W  = 10;
  localparam int STAT_W  = 2;
  localparam int CFG_DATA_W  = 20;
  localparam int CFG_INDEX_W = 3;
  localparam int CMP_W = ((COUNTER_BITS > LIMIT_W) ? COUNTER_BITS : LIMIT_W) + 1;
  localparam int PROD_W = COUNTER_BITS + SCALE_W;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_TRIGGER_TICKS      = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_RISE_TIMEOUT_TICKS = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_HIGH_TIMEOUT_TICKS = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_REPEAT_GAP_TICKS   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_SCALE_Q16          = 3'd4;

  // register reset values
  localparam logic [TRIG_W-1:0]  TRIGGER_TICKS_RST      = 10'd10;
  localparam logic [LIMIT_W-1:0] RISE_TIMEOUT_TICKS_RST = 20'd10000;
  localparam logic [LIMIT_W-1:0] HIGH_TIMEOUT_TICKS_RST = 20'd50000;
  localparam logic [LIMIT_W-1:0] REPEAT_GAP_TICKS_RST   = 20'd500000;
  localparam logic [SCALE_W-1:0] SCALE_Q16_RST          = 16'd1114;

  // measurement phases
  localparam logic [1:0] PH_GAP  = 2'd0;
  localparam logic [1:0] PH_TRIG = 2'd1;
  localparam logic [1:0] PH_WAIT = 2'd2;
  localparam logic [1:0] PH_HIGH = 2'd3;

  // result status codes
  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_NO_ECHO  = 2'd1;
  localparam logic [STAT_W-1:0] ST_TOO_LONG = 2'd2;

  localparam logic [DIST_W-1:0]       DIST_MAX = '1;
  localparam logic [COUNTER_BITS-1:0] CNT_MAX  = '1;

  typedef logic [COUNTER_BITS-1:0] cnt_t;

  typedef struct packed {
    logic              trigger_level;
    logic              done_res;
    logic [DIST_W-1:0] distance_cm;
    logic [STAT_W-1:0] status;
  } result_t;

  // saturating increment
  function automatic cnt_t cnt_inc(input cnt_t c);
    cnt_inc = (c == CNT_MAX) ? c : c + cnt_t'(1);
  endfunction

  // a saturated counter has reached any limit
  function automatic logic reached(input cnt_t c, input logic [LIMIT_W-1:0] limit);
    reached = (CMP_W'(c) >= CMP_W'(limit)) || (c == CNT_MAX);
  endfunction

endpackage

// ===== sv/uer_if.sv =====
// valid/ready stream interfaces for the tick input and the result output
interface uer_in_if
  import uer_pkg::*;
;
  logic valid;
  logic ready;
  logic echo_level;
  logic run_enable;

  modport source (output valid, output echo_level, output run_enable, input ready);
  modport sink   (input valid, input echo_level, input run_enable, output ready);
endinterface

interface uer_out_if
  import uer_pkg::*;
;
  logic              valid;
  logic              ready;
  logic              trigger_level;
  logic              done_res;
  logic [DIST_W-1:0] distance_cm;
  logic [STAT_W-1:0] status;

  modport source (output valid, output trigger_level, output done_res,
                  output distance_cm, output status, input ready);
  modport sink   (input valid, input trigger_level, input done_res,
                  input distance_cm, input status, output ready);
endinterface

// ===== sv/ultrasonic_echo_ranger.sv =====
// ultrasonic echo ranger: trigger, echo timing and distance per microsecond tick
// Each accepted transaction on in_ch is one timebase tick and yields exactly one
// transaction on out_ch, in order. A tick is worked out in the cycle it is taken
// (phase counters, trigger level, and the echo width times scale_q16 product,
// a 20 x 16 bit multiply) and is registered in the output or, if that is full,
// the skid register. The block takes one tick per cycle; a two-entry output
// buffer (output register plus skid register) keeps in_ch.ready high while one
// result waits, and ready drops only while both entries are full. Configuration
// registers are written by index through cfg_wr_en, cfg_index and cfg_data and
// take effect on the next tick; an index beyond the register list is ignored.
module ultrasonic_echo_ranger
  import uer_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  uer_in_if.sink                 in_ch,
  uer_out_if.source              out_ch,
  input  logic                   cfg_wr_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  // configuration registers
  logic [TRIG_W-1:0]  trigger_ticks;
  logic [LIMIT_W-1:0] rise_timeout_ticks;
  logic [LIMIT_W-1:0] high_timeout_ticks;
  logic [LIMIT_W-1:0] repeat_gap_ticks;
  logic [SCALE_W-1:0] scale_q16;

  // measurement state
  logic [1:0] phase;
  logic [1:0] phase_next;
  cnt_t       phase_count;
  cnt_t       phase_count_next;
  cnt_t       echo_width;
  cnt_t       echo_width_next;

  // output buffer
  logic    out_valid;
  result_t out_res;
  logic    skid_valid;
  result_t skid_res;

  logic    accept;
  logic    pop;
  result_t res;
  cnt_t    pc_inc;
  logic [PROD_W-1:0]       product;
  logic [COUNTER_BITS-1:0] dist_full;
  logic [DIST_W-1:0]       dist_sat;

  assign in_ch.ready = !skid_valid;
  assign accept      = in_ch.valid && in_ch.ready;
  assign pop         = out_valid && out_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      trigger_ticks      <= TRIGGER_TICKS_RST;
      rise_timeout_ticks <= RISE_TIMEOUT_TICKS_RST;
      high_timeout_ticks <= HIGH_TIMEOUT_TICKS_RST;
      repeat_gap_ticks   <= REPEAT_GAP_TICKS_RST;
      scale_q16          <= SCALE_Q16_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_TRIGGER_TICKS:      trigger_ticks      <= cfg_data[TRIG_W-1:0];
        REG_RISE_TIMEOUT_TICKS: rise_timeout_ticks <= cfg_data[LIMIT_W-1:0];
        REG_HIGH_TIMEOUT_TICKS: high_timeout_ticks <= cfg_data[LIMIT_W-1:0];
        REG_REPEAT_GAP_TICKS:   repeat_gap_ticks   <= cfg_data[LIMIT_W-1:0];
        REG_SCALE_Q16:          scale_q16          <= cfg_data[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // distance = width * scale >> 16, saturated
  assign product   = PROD_W'(echo_width) * PROD_W'(scale_q16);
  assign dist_full = product[PROD_W-1:SCALE_W];
  assign dist_sat  = (dist_full > COUNTER_BITS'(DIST_MAX)) ? DIST_MAX
                                                           : dist_full[DIST_W-1:0];
  assign pc_inc    = cnt_inc(phase_count);

  always_comb begin
    phase_next       = phase;
    phase_count_next = phase_count;
    echo_width_next  = echo_width;
    res.trigger_level = (phase == PH_TRIG);
    res.done_res      = 1'b0;
    res.distance_cm   = '0;
    res.status        = ST_OK;

    unique case (phase)
      PH_GAP: begin
        phase_count_next = pc_inc;
        if (reached(pc_inc, repeat_gap_ticks) && in_ch.run_enable) begin
          phase_next       = PH_TRIG;
          phase_count_next = '0;
        end
      end
      PH_TRIG: begin
        phase_count_next = pc_inc;
        if (reached(pc_inc, LIMIT_W'(trigger_ticks))) begin
          phase_next       = PH_WAIT;
          phase_count_next = '0;
        end
      end
      PH_WAIT: begin
        if (in_ch.echo_level) begin
          phase_next      = PH_HIGH;
          echo_width_next = cnt_t'(1);
        end else begin
          phase_count_next = pc_inc;
          if (reached(pc_inc, rise_timeout_ticks)) begin
            res.done_res = 1'b1;
            res.status   = ST_NO_ECHO;
          end
        end
      end
      PH_HIGH: begin
        if (!in_ch.echo_level) begin
          res.done_res    = 1'b1;
          res.status      = ST_OK;
          res.distance_cm = dist_sat;
        end else if (reached(echo_width, high_timeout_ticks)) begin
          res.done_res = 1'b1;
          res.status   = ST_TOO_LONG;
        end else begin
          echo_width_next = cnt_inc(echo_width);
        end
      end
    endcase

    if (res.done_res) begin
      phase_next       = PH_GAP;
      phase_count_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_GAP;
      phase_count <= '0;
      echo_width  <= '0;
    end else if (accept) begin
      phase       <= phase_next;
      phase_count <= phase_count_next;
      echo_width  <= echo_width_next;
    end
  end

  // output register with skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || pop) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || pop) begin
      out_res <= skid_valid ? skid_res : res;
    end
    if (accept && out_valid && !pop) begin
      skid_res <= res;
    end
  end

  assign out_ch.valid         = out_valid;
  assign out_ch.trigger_level = out_res.trigger_level;
  assign out_ch.done_res      = out_res.done_res;
  assign out_ch.distance_cm   = out_res.distance_cm;
  assign out_ch.status        = out_res.status;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held while output register empty");

  a_idle_result_clear: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_res.done_res) |->
      (out_res.status == ST_OK && out_res.distance_cm == '0))
    else $error("status or distance set on a tick without completion");

  a_fail_no_distance: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_res.done_res && out_res.status != ST_OK) |->
      (out_res.distance_cm == '0 &&
       (out_res.status == ST_NO_ECHO || out_res.status == ST_TOO_LONG)))
    else $error("failed measurement carries a distance or bad status");

  a_high_width_nonzero: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_HIGH) |-> (echo_width != '0))
    else $error("echo high phase with zero width");

  a_trigger_ends_wait: assert property (@(posedge clk) disable iff (rst)
    (accept && phase == PH_TRIG && phase_next != PH_TRIG) |=> (phase == PH_WAIT))
    else $error("trigger phase left for a phase other than wait");

endmodule
